// ----- src/frame_change_bounding_box_core_defines.svh -----
// assertion macros for the frame change bounding box core
// used by the top level; no dependencies
`ifndef FRAME_CHANGE_BOUNDING_BOX_CORE_DEFINES_SVH
`define FRAME_CHANGE_BOUNDING_BOX_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FCBB_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("fcbb assertion failed");
`define FCBB_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("fcbb assertion failed");
`else
`define FCBB_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define FCBB_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ----- src/fcbb_pkg.sv -----
// shared types and constants of the frame change bounding box core
// no dependencies
package fcbb_pkg;

    localparam int CFG_W      = 13;
    localparam int STEP_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int PIX_W      = 32;
    localparam int POS_OUT_W  = 12;
    localparam int DIM_OUT_W  = 13;

    localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 13'd1920;
    localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd1080;
    localparam logic [STEP_W-1:0] RST_HORZ_STEP    = 7'd1;

    // rectangle padding around the changed samples
    localparam int PAD_LEFT   = 1;
    localparam int PAD_TOP    = 3;
    localparam int PAD_RIGHT  = 3;
    localparam int PAD_BOTTOM = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_HORZ_STEP    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] old_pixel_a;
        logic [PIX_W-1:0] old_pixel_b;
        logic [PIX_W-1:0] new_pixel_a;
        logic [PIX_W-1:0] new_pixel_b;
    } t_in_item;

    typedef struct packed {
        logic                 box_empty;
        logic [POS_OUT_W-1:0] box_top;
        logic [POS_OUT_W-1:0] box_left;
        logic [DIM_OUT_W-1:0] box_width;
        logic [DIM_OUT_W-1:0] box_height;
    } t_out_item;

    typedef struct packed {
        logic changed;
        logic last;
    } t_smp_flags;

endpackage

// ----- src/fcbb_sampler.sv -----
// sample stage: pair-sum compare and raster position stepping
// depends on fcbb_pkg
module fcbb_sampler #(
    parameter int CW  = 12,
    parameter int RW  = 12,
    parameter int WEW = 13,
    parameter int HEW = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  fcbb_pkg::t_in_item          i_pix,
    input  logic [WEW-1:0]              i_width,
    input  logic [HEW-1:0]              i_height,
    input  logic [fcbb_pkg::STEP_W-1:0] i_step,
    output fcbb_pkg::t_smp_flags        o_flags,
    output logic [CW-1:0]               o_x,
    output logic [RW-1:0]               o_y
);

    localparam int XSW = CW + 2;

    logic [CW-1:0]            r_col;
    logic [RW-1:0]            r_row;
    logic [CW-1:0]            n_col;
    logic [RW-1:0]            n_row;
    fcbb_pkg::t_smp_flags     r_flags;
    fcbb_pkg::t_smp_flags     n_flags;
    logic [CW-1:0]            r_x;
    logic [RW-1:0]            r_y;
    logic [fcbb_pkg::PIX_W-1:0] sum_old;
    logic [fcbb_pkg::PIX_W-1:0] sum_new;
    logic [XSW-1:0]           col_ext;
    logic [XSW-1:0]           reach;
    logic [RW:0]              row_inc;
    logic                     wrap;
    logic                     row_end;

    always_comb begin
        sum_old = i_pix.old_pixel_a + i_pix.old_pixel_b;
        sum_new = i_pix.new_pixel_a + i_pix.new_pixel_b;
        col_ext = XSW'(r_col);
        reach   = col_ext + (XSW'(i_step) << 1);
        wrap    = reach > XSW'(i_width);
        row_inc = (RW+1)'(r_row) + (RW+1)'(1);
        row_end = row_inc >= (RW+1)'(i_height);

        n_flags.changed = sum_old != sum_new;
        n_flags.last    = wrap && row_end;

        if (!wrap) begin
            n_col = CW'(col_ext + XSW'(i_step));
            n_row = r_row;
        end else if (row_end) begin
            n_col = '0;
            n_row = '0;
        end else begin
            n_col = '0;
            n_row = RW'(row_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // sample payload, meaningful only while the stage holds an item
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flags <= n_flags;
            r_x     <= r_col;
            r_y     <= r_row;
        end
    end

    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;

endmodule

// ----- src/fcbb_box.sv -----
// box stage: bounding box tracking, padding and result register
// depends on fcbb_pkg
module fcbb_box #(
    parameter int CW  = 12,
    parameter int RW  = 12,
    parameter int WEW = 13,
    parameter int HEW = 13
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  fcbb_pkg::t_smp_flags i_flags,
    input  logic [CW-1:0]        i_x,
    input  logic [RW-1:0]        i_y,
    input  logic [WEW-1:0]       i_width,
    input  logic [HEW-1:0]       i_height,
    output fcbb_pkg::t_out_item  o_box
);

    localparam int RX = CW + 3;
    localparam int BX = RW + 2;

    logic                r_seen;
    logic [RW-1:0]       r_top;
    logic [RW:0]         r_bot;
    logic [CW-1:0]       r_left;
    logic [CW:0]         r_right;
    logic                n_seen;
    logic [RW-1:0]       n_top;
    logic [RW:0]         n_bot;
    logic [CW-1:0]       n_left;
    logic [CW:0]         n_right;
    logic [CW:0]         x_next;
    logic [CW-1:0]       p_left;
    logic [RW-1:0]       p_top;
    logic [CW:0]         p_right;
    logic [RW:0]         p_bot;
    logic [RX-1:0]       rgt_ext;
    logic [RX-1:0]       wid_ext;
    fcbb_pkg::t_out_item r_box;
    fcbb_pkg::t_out_item n_box;

    // box update with the current sample
    always_comb begin
        x_next  = (CW+1)'(i_x) + (CW+1)'(1);
        n_seen  = r_seen;
        n_top   = r_top;
        n_bot   = r_bot;
        n_left  = r_left;
        n_right = r_right;
        if (i_flags.changed) begin
            n_seen = 1'b1;
            n_bot  = (RW+1)'(i_y) + (RW+1)'(1);
            if (!r_seen) begin
                n_top   = i_y;
                n_left  = i_x;
                n_right = x_next;
            end else begin
                if (i_x < r_left) begin
                    n_left = i_x;
                end
                if (r_right < x_next) begin
                    n_right = x_next;
                end
            end
        end
    end

    // padding, clamped to the frame
    always_comb begin
        p_left = (n_left != '0) ? n_left - CW'(fcbb_pkg::PAD_LEFT) : n_left;
        p_top  = (n_top >= RW'(fcbb_pkg::PAD_TOP)) ? n_top - RW'(fcbb_pkg::PAD_TOP) : '0;

        rgt_ext = RX'(n_right);
        wid_ext = RX'(i_width);
        if (rgt_ext + RX'(1) < wid_ext) begin
            if (rgt_ext + RX'(fcbb_pkg::PAD_RIGHT + 1) < wid_ext) begin
                p_right = n_right + (CW+1)'(fcbb_pkg::PAD_RIGHT);
            end else begin
                p_right = (CW+1)'(i_width) - (CW+1)'(1);
            end
        end else begin
            p_right = n_right;
        end

        if (BX'(n_bot) + BX'(fcbb_pkg::PAD_BOTTOM) < BX'(i_height)) begin
            p_bot = n_bot + (RW+1)'(fcbb_pkg::PAD_BOTTOM);
        end else begin
            p_bot = n_bot;
        end

        if (!n_seen) begin
            n_box           = '0;
            n_box.box_empty = 1'b1;
        end else begin
            n_box.box_empty  = 1'b0;
            n_box.box_top    = fcbb_pkg::POS_OUT_W'(p_top);
            n_box.box_left   = fcbb_pkg::POS_OUT_W'(p_left);
            n_box.box_width  = fcbb_pkg::DIM_OUT_W'(p_right - (CW+1)'(p_left));
            n_box.box_height = fcbb_pkg::DIM_OUT_W'(p_bot - (RW+1)'(p_top));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_top   <= '0;
            r_bot   <= '0;
            r_left  <= '0;
            r_right <= '0;
        end else if (i_adv) begin
            if (i_flags.last) begin
                r_seen  <= 1'b0;
                r_top   <= '0;
                r_bot   <= '0;
                r_left  <= '0;
                r_right <= '0;
            end else begin
                r_seen  <= n_seen;
                r_top   <= n_top;
                r_bot   <= n_bot;
                r_left  <= n_left;
                r_right <= n_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_flags.last) begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

// ----- src/frame_change_bounding_box_core.sv -----
// top level of the frame change bounding box core
// depends on fcbb_pkg, fcbb_sampler, fcbb_box and the assertion macro header
//
// usage
//   input channel: one transaction per sampled position of a frame, in raster
//   order, carrying two adjacent pixels of the old frame and the same two of
//   the new frame; a sample is changed when the wrapped pair sums differ
//   output channel: one transaction per frame, sent after the last sample of
//   that frame: the padded rectangle around all changed samples, or the
//   empty flag with zero fields when nothing changed
//   config port: frame width, frame height and column step, written while
//   the core is idle; they take effect on the next sample
// timing
//   three register stages: input register, sample register, result register;
//   the rectangle is offered from the result register once the frame end leaves the sample stage
//   one sample per cycle sustained while no frame end waits on a stalled result;
//   the pair compare and the box min/max update each sit between two registers
// reset
//   synchronous, active low; clears position, box and all valid flags and
//   loads 1920 x 1080 with step 1
// back-pressure
//   a stalled result holds; samples keep flowing until a second frame end
//   reaches the sample register, then the stall walks back to o_in_stall
`include "frame_change_bounding_box_core_defines.svh"

module frame_change_bounding_box_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fcbb_pkg::t_in_item             i_in_data,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fcbb_pkg::t_out_item            o_out_data,
    // config write port
    input  logic                           i_cfg_we,
    input  logic [fcbb_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [fcbb_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int HEW = $clog2(MAX_HEIGHT + 1);

    // config registers
    logic [fcbb_pkg::CFG_W-1:0]  r_frame_width;
    logic [fcbb_pkg::CFG_W-1:0]  r_frame_height;
    logic [fcbb_pkg::STEP_W-1:0] r_horz_step;

    // effective geometry, clamped to the supported frame size
    logic [WEW-1:0]              eff_width;
    logic [HEW-1:0]              eff_height;
    logic [fcbb_pkg::STEP_W-1:0] eff_step;

    // pipeline control
    logic                 r_in_valid;
    fcbb_pkg::t_in_item   r_in;
    logic                 r_smp_valid;
    logic                 r_out_valid;
    logic                 out_ready;
    logic                 smp_adv;
    logic                 smp_free;
    logic                 in_adv;
    logic                 in_take;

    fcbb_pkg::t_smp_flags smp_flags;
    logic [CW-1:0]        smp_x;
    logic [RW-1:0]        smp_y;
    fcbb_pkg::t_out_item  box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= fcbb_pkg::RST_FRAME_WIDTH;
            r_frame_height <= fcbb_pkg::RST_FRAME_HEIGHT;
            r_horz_step    <= fcbb_pkg::RST_HORZ_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                fcbb_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_wdata;
                end
                fcbb_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_wdata;
                end
                fcbb_pkg::CFG_HORZ_STEP: begin
                    r_horz_step <= i_cfg_wdata[fcbb_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero height counts as one row, zero step as one column
    always_comb begin
        eff_width = (32'(r_frame_width) > 32'(MAX_WIDTH)) ? WEW'(MAX_WIDTH)
                                                          : WEW'(r_frame_width);
        if (r_frame_height == '0) begin
            eff_height = HEW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            eff_height = HEW'(MAX_HEIGHT);
        end else begin
            eff_height = HEW'(r_frame_height);
        end
        eff_step = (r_horz_step == '0) ? fcbb_pkg::STEP_W'(1) : r_horz_step;
    end

    // flow control: only a frame end needs room in the result register
    always_comb begin
        out_ready  = !r_out_valid || !i_out_stall;
        smp_adv    = r_smp_valid && (!smp_flags.last || out_ready);
        smp_free   = !r_smp_valid || smp_adv;
        in_adv     = r_in_valid && smp_free;
        o_in_stall = r_in_valid && !in_adv;
        in_take    = i_in_valid && !o_in_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_smp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (in_adv) begin
                r_in_valid <= 1'b0;
            end
            if (in_adv) begin
                r_smp_valid <= 1'b1;
            end else if (smp_adv) begin
                r_smp_valid <= 1'b0;
            end
            if (smp_adv && smp_flags.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    fcbb_sampler #(
        .CW  (CW),
        .RW  (RW),
        .WEW (WEW),
        .HEW (HEW)
    ) u_sampler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (in_adv),
        .i_pix    (r_in),
        .i_width  (eff_width),
        .i_height (eff_height),
        .i_step   (eff_step),
        .o_flags  (smp_flags),
        .o_x      (smp_x),
        .o_y      (smp_y)
    );

    fcbb_box #(
        .CW  (CW),
        .RW  (RW),
        .WEW (WEW),
        .HEW (HEW)
    ) u_box (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (smp_adv),
        .i_flags  (smp_flags),
        .i_x      (smp_x),
        .i_y      (smp_y),
        .i_width  (eff_width),
        .i_height (eff_height),
        .o_box    (box)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = box;

    // a frame end leaving the sample stage always lands in the result register
    `FCBB_ASSERT_NXT(a_frame_end_loads_out, i_clk, i_rst_n, smp_adv && smp_flags.last, r_out_valid)
    // a sample moving on from the input register is held in the sample stage
    `FCBB_ASSERT_NXT(a_sample_reaches_stage, i_clk, i_rst_n, in_adv, r_smp_valid)
    // a held input transaction keeps its payload
    `FCBB_ASSERT_NXT(a_input_held, i_clk, i_rst_n, r_in_valid && !in_adv, r_in_valid && $stable(r_in))
    // only a frame end in the sample stage can back-pressure the input
    `FCBB_ASSERT_IMP(a_stall_only_on_end, i_clk, i_rst_n, o_in_stall, r_smp_valid && smp_flags.last)

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for frame_change_bounding_box_core: random frames of
// changed and unchanged pixel pairs, checked against a local box predictor
// depends on fcbb_pkg and the core's RTL only
`timescale 1ns / 1ps

module testbench;
    import fcbb_pkg::*;

    localparam int FRAME_MAX_W = 4096;
    localparam int FRAME_MAX_H = 4096;
    localparam int HALF_PERIOD = 10;
    // three register stages plus margin
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // tracks the dirty rectangle of the frame in flight and holds the
    // rectangles still owed by the core
    class dirty_box_tracker;
        logic [CFG_W-1:0]  width  = RST_FRAME_WIDTH;
        logic [CFG_W-1:0]  height = RST_FRAME_HEIGHT;
        logic [STEP_W-1:0] step   = RST_HORZ_STEP;
        int unsigned col, row;
        bit          seen;
        int unsigned top_edge, bot_edge, left_edge, right_edge;
        t_out_item   boxes_due[$];
        int unsigned samples, frames, empties, checked, errors;

        function void clear_box();
            col = 0;
            row = 0;
            seen = 0;
            top_edge = 0;
            bot_edge = 0;
            left_edge = 0;
            right_edge = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_FRAME_WIDTH:  width = val;
                CFG_FRAME_HEIGHT: height = val;
                CFG_HORZ_STEP:    step = val[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_in_item smp);
            int unsigned w, h, s, x, y, lft, rgt, top, bot;
            logic [PIX_W-1:0] sum_old, sum_new;
            t_out_item box;
            bit last;
            w = (width > FRAME_MAX_W) ? FRAME_MAX_W : width;
            h = (height > FRAME_MAX_H) ? FRAME_MAX_H : height;
            if (h == 0) h = 1;
            s = (step == 0) ? 1 : step;
            x = col;
            y = row;
            samples++;
            sum_old = smp.old_pixel_a + smp.old_pixel_b;
            sum_new = smp.new_pixel_a + smp.new_pixel_b;
            if (sum_old != sum_new) begin
                if (!seen) begin
                    seen = 1;
                    top_edge = y;
                    left_edge = x;
                    right_edge = x + 1;
                end else begin
                    if (x < left_edge) left_edge = x;
                    if (right_edge < x + 1) right_edge = x + 1;
                end
                bot_edge = y + 1;
            end
            last = 0;
            if (x + 2 * s <= w) begin
                col = x + s;
            end else begin
                col = 0;
                if (y + 1 >= h) last = 1;
                else row = y + 1;
            end
            if (!last) return;
            box = '0;
            if (!seen) begin
                box.box_empty = 1'b1;
                empties++;
            end else begin
                lft = left_edge;
                if (lft > 0) lft = lft - PAD_LEFT;
                top = (top_edge >= PAD_TOP) ? top_edge - PAD_TOP : 0;
                rgt = right_edge;
                // right edge only grows when it is short of the last column
                if (rgt + 1 < w)
                    rgt = (rgt + PAD_RIGHT + 1 < w) ? rgt + PAD_RIGHT : w - 1;
                bot = bot_edge;
                if (bot + 1 < h) bot = bot + PAD_BOTTOM;
                box.box_top    = POS_OUT_W'(top);
                box.box_left   = POS_OUT_W'(lft);
                box.box_width  = DIM_OUT_W'(rgt - lft);
                box.box_height = DIM_OUT_W'(bot - top);
            end
            boxes_due.push_back(box);
            frames++;
            clear_box();
        endfunction

        function void check_box(t_out_item got);
            t_out_item want;
            if (boxes_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: rectangle with none due:", $realtime,
                             " empty=%0d top=%0d left=%0d w=%0d h=%0d",
                             got.box_empty, got.box_top, got.box_left,
                             got.box_width, got.box_height);
                return;
            end
            want = boxes_due.pop_front();
            checked++;
            if (got.box_empty !== want.box_empty || got.box_top !== want.box_top ||
                got.box_left !== want.box_left || got.box_width !== want.box_width ||
                got.box_height !== want.box_height) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: rectangle mismatch:", $realtime,
                             " expected empty=%0d top=%0d left=%0d w=%0d h=%0d,",
                             want.box_empty, want.box_top, want.box_left,
                             want.box_width, want.box_height,
                             " got empty=%0d top=%0d left=%0d w=%0d h=%0d",
                             got.box_empty, got.box_top, got.box_left,
                             got.box_width, got.box_height);
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    t_in_item          in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    t_out_item         out_data;
    logic              cfg_we = 1'b0;
    t_cfg_idx          cfg_addr = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    dirty_box_tracker  sb = new();
    // quiet stretches: neither side idles nor stalls
    bit                quiet = 1'b0;
    int unsigned       rx_hold = 0;
    int unsigned       phases = 0;
    int unsigned       rand_from, frames_from;

    frame_change_bounding_box_core #(
        .MAX_WIDTH(FRAME_MAX_W),
        .MAX_HEIGHT(FRAME_MAX_H)
    ) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(0, 6);
    endfunction

    // extremes show up often enough to matter
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // changed with the given chance per thousand; unchanged samples are
    // either plain copies or different pixels with the same wrapped sum
    function automatic t_in_item make_sample(int unsigned permille);
        t_in_item smp;
        logic [PIX_W-1:0] sum_old, sum_new;
        smp.old_pixel_a = rand_pixel();
        smp.old_pixel_b = rand_pixel();
        sum_old = smp.old_pixel_a + smp.old_pixel_b;
        if ($urandom_range(0, 999) < permille) begin
            smp.new_pixel_a = rand_pixel();
            smp.new_pixel_b = rand_pixel();
            sum_new = smp.new_pixel_a + smp.new_pixel_b;
            if (sum_new == sum_old) smp.new_pixel_b = smp.new_pixel_b ^ 32'd1;
        end else if ($urandom_range(0, 1) == 0) begin
            smp.new_pixel_a = smp.old_pixel_a;
            smp.new_pixel_b = smp.old_pixel_b;
        end else begin
            smp.new_pixel_a = rand_pixel();
            smp.new_pixel_b = sum_old - smp.new_pixel_a;
        end
        return smp;
    endfunction

    function automatic int unsigned pick_rate();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 30;
            2:       return 250;
            default: return 1000;
        endcase
    endfunction

    // one sample transaction; prediction is taken at the accepting edge
    task automatic send_sample(t_in_item smp);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= smp;
        do @(posedge clk); while (in_stall);
        sb.note_sample(smp);
    endtask

    // sender holds off until every owed rectangle is back, then lets the
    // pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.boxes_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all three registers back to back; junk above the step field is dropped
    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned s);
        logic [CFG_W-1:0] step_word;
        step_word = {6'($urandom_range(0, 63)), 7'(s)};
        cfg_we <= 1'b1;
        cfg_addr <= CFG_FRAME_WIDTH;
        cfg_wdata <= CFG_W'(w);
        @(posedge clk);
        cfg_addr <= CFG_FRAME_HEIGHT;
        cfg_wdata <= CFG_W'(h);
        @(posedge clk);
        cfg_addr <= CFG_HORZ_STEP;
        cfg_wdata <= step_word;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(CFG_FRAME_WIDTH, CFG_W'(w));
        sb.set_reg(CFG_FRAME_HEIGHT, CFG_W'(h));
        sb.set_reg(CFG_HORZ_STEP, step_word);
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned s,
                             int unsigned nframes, int unsigned permille);
        int unsigned target;
        drain();
        set_geometry(w, h, s);
        phases++;
        repeat (nframes) begin
            target = sb.frames + 1;
            while (sb.frames < target) send_sample(make_sample(permille));
            // now and then a full pause at a frame boundary
            if ($urandom_range(0, 11) == 0) drain();
            quiet <= ($urandom_range(0, 3) == 0);
        end
    endtask

    // result side: after each rectangle, stall the next one for a random
    // number of its valid cycles
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                sb.check_box(out_data);
                rx_hold = draw_wait();
            end else if (out_valid && rx_hold != 0) begin
                rx_hold = rx_hold - 1;
            end
            out_stall <= (rx_hold != 0);
        end
    end

    initial begin
        t_in_item opening [12];
        // 8 x 3 frame, step 2: four samples per row
        opening[0]  = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
        opening[1]  = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        // pair sums wrap to the same value
        opening[2]  = {32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000};
        opening[3]  = {32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000};
        // first change, left column
        opening[4]  = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001};
        opening[5]  = {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        // swapped pixels keep the sum
        opening[6]  = {32'h1234_5678, 32'h9ABC_DEF0, 32'h9ABC_DEF0, 32'h1234_5678};
        // change at the last sample column
        opening[7]  = {32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000};
        opening[8]  = {32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555};
        opening[9]  = {32'h0000_0001, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000};
        opening[10] = {32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        opening[11] = {32'hDEAD_BEEF, 32'h0000_0000, 32'hDEAD_BEEF, 32'h0000_0000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_geometry(8, 3, 2);
        phases++;
        for (int i = 0; i < 12; i++) send_sample(opening[i]);
        // smallest legal frame, nothing changed
        run_phase(2, 1, 1, 2, 0);

        // zero width, height and step: every sample is a whole frame
        run_phase(0, 0, 0, 8, 500);
        // width past the maximum, step of 64 columns
        run_phase(8191, 1, 64, 1, 30);
        run_phase(4095, 1, 64, 1, 30);
        // width below step: every sample is a row of its own
        run_phase(5, 3, 64, 1, 500);
        // width equal to step
        run_phase(64, 2, 64, 1, 500);
        run_phase(1, 1, 127, 3, 500);

        rand_from = sb.samples;
        frames_from = sb.frames;
        while (sb.samples < rand_from + 250 || sb.frames < frames_from + 30) begin
            if ($urandom_range(0, 7) == 0)
                run_phase($urandom_range(64, 8191), $urandom_range(0, 2),
                          $urandom_range(32, 127), 1, pick_rate());
            else
                run_phase($urandom_range(0, 16), $urandom_range(0, 4),
                          $urandom_range(0, 6), $urandom_range(1, 4), pick_rate());
        end
        drain();

        $display("testbench: %0d samples over %0d geometry settings,",
                 sb.samples, phases,
                 " %0d rectangles checked (%0d empty)", sb.checked, sb.empties);
        $display("testbench: %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.boxes_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // well beyond the slowest correct run
    initial begin
        #(64'd2_000_000);
        $display("testbench: timeout with %0d rectangles outstanding", sb.boxes_due.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/fcbb_pkg.sv
src/fcbb_sampler.sv
src/fcbb_box.sv
src/frame_change_bounding_box_core.sv
dv/testbench.sv
